// ===== rtl/core/utt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants and the job record passed from the front to the back end.
// ----------------------------------------------------------------------------
package utt_pkg;

	localparam int QDepth    = 4;
	localparam int QPtrW     = $clog2(QDepth);
	localparam int QCntW     = $clog2(QDepth + 1);
	localparam int MaxBytes  = 4;
	localparam int SlotW     = $clog2(MaxBytes);
	localparam int CpW       = 21;

	localparam logic [5:0]     HighSurPrefix = 6'b110110;
	localparam logic [5:0]     LowSurPrefix  = 6'b110111;
	localparam logic [CpW-1:0] CpSupplBase   = 21'h10000;
	localparam logic [CpW-1:0] CpTwoByte     = 21'h80;
	localparam logic [CpW-1:0] CpThreeByte   = 21'h800;
	localparam logic [CpW-1:0] CpFourByte    = 21'h10000;
	localparam logic [7:0]     ErrByte       = 8'h00;

	// up to four result slots, filled from slot 0
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [MaxBytes-1:0]      bad;
		logic [SlotW-1:0]         last_idx;
	} job_t;

endpackage

// ===== rtl/core/utt_unit_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 code unit channel
// Valid/ready channel carrying one code unit and an end-of-text mark.
// ----------------------------------------------------------------------------
interface utt_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_text;

	modport source (output valid, output code_unit, output end_of_text, input ready);
	modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

// ===== rtl/core/utt_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 byte channel
// Valid/ready channel carrying one output byte with run and error marks.
// ----------------------------------------------------------------------------
interface utt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       bad_surrogate;

	modport source (output valid, output out_byte, output last_of_run,
		output bad_surrogate, input ready);
	modport sink   (input valid, input out_byte, input last_of_run,
		input bad_surrogate, output ready);
endinterface

// ===== rtl/core/utt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts code units, pairs surrogates and builds a byte job for each unit that gives results.
// ----------------------------------------------------------------------------
module utt_front (
	input  logic          clk,
	input  logic          arst_n,
	utt_unit_if.sink      unit_in,
	input  logic          q_full,
	output logic          q_push,
	output utt_pkg::job_t q_job
);
	import utt_pkg::*;

	logic           held_valid_q;
	logic [9:0]     held_high_bits_q;
	logic           is_high;
	logic           is_low;
	logic           pair;
	logic           err_first;
	logic           hold_new;
	logic           err_tail;
	logic [CpW-1:0] cp;
	logic [2:0]     enc_cnt;
	logic [MaxBytes-1:0][7:0] enc;
	logic [2:0]     n;
	logic           accept;

	assign unit_in.ready = !q_full;
	assign accept        = unit_in.valid && unit_in.ready;

	assign is_high   = (unit_in.code_unit[15:10] == HighSurPrefix);
	assign is_low    = (unit_in.code_unit[15:10] == LowSurPrefix);
	assign pair      = held_valid_q && is_low;
	assign err_first = held_valid_q && !is_low;
	assign hold_new  = !pair && is_high;
	assign err_tail  = hold_new && unit_in.end_of_text;

	always_comb begin
		if (pair) begin
			cp = CpSupplBase + {1'b0, held_high_bits_q, unit_in.code_unit[9:0]};
		end else begin
			cp = {5'd0, unit_in.code_unit};
		end
	end

	// UTF-8 encoding of the code point
	always_comb begin
		enc = '0;
		if (cp < CpTwoByte) begin
			enc_cnt = 3'd1;
			enc[0]  = cp[7:0];
		end else if (cp < CpThreeByte) begin
			enc_cnt = 3'd2;
			enc[0]  = {3'b110, cp[10:6]};
			enc[1]  = {2'b10, cp[5:0]};
		end else if (cp < CpFourByte) begin
			enc_cnt = 3'd3;
			enc[0]  = {4'b1110, cp[15:12]};
			enc[1]  = {2'b10, cp[11:6]};
			enc[2]  = {2'b10, cp[5:0]};
		end else begin
			enc_cnt = 3'd4;
			enc[0]  = {5'b11110, cp[20:18]};
			enc[1]  = {2'b10, cp[17:12]};
			enc[2]  = {2'b10, cp[11:6]};
			enc[3]  = {2'b10, cp[5:0]};
		end
	end

	// pack error results and encoded bytes into consecutive slots
	always_comb begin
		q_job = '0;
		n     = 3'd0;
		if (err_first) begin
			q_job.bytes[n[SlotW-1:0]] = ErrByte;
			q_job.bad[n[SlotW-1:0]]   = 1'b1;
			n = n + 3'd1;
		end
		if (!hold_new) begin
			for (int k = 0; k < MaxBytes; k++) begin
				if (3'(k) < enc_cnt) begin
					q_job.bytes[n[SlotW-1:0]] = enc[k];
					n = n + 3'd1;
				end
			end
		end
		if (err_tail) begin
			q_job.bytes[n[SlotW-1:0]] = ErrByte;
			q_job.bad[n[SlotW-1:0]]   = 1'b1;
			n = n + 3'd1;
		end
		q_job.last_idx = SlotW'(n - 3'd1);
	end

	// a held high surrogate alone produces nothing
	assign q_push = accept && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q     <= 1'b0;
			held_high_bits_q <= '0;
		end else if (accept) begin
			held_valid_q     <= hold_new && !unit_in.end_of_text;
			held_high_bits_q <= (hold_new && !unit_in.end_of_text) ?
				unit_in.code_unit[9:0] : 10'd0;
		end
	end

endmodule

// ===== rtl/core/utt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder job queue
// Small FIFO of byte jobs between the front and back ends.
// ----------------------------------------------------------------------------
module utt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  utt_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output utt_pkg::job_t head_job
);
	import utt_pkg::*;

	job_t             slots_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full       = (count_q == QCntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/utt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder back end
// Walks the slots of the head job and drives one byte per transaction.
// ----------------------------------------------------------------------------
module utt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  utt_pkg::job_t head_job,
	output logic          pop,
	utt_byte_if.source    byte_out
);
	import utt_pkg::*;

	logic [SlotW-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             bad_q;
	logic             load;
	logic             at_last;

	assign load    = head_valid && (!valid_q || byte_out.ready);
	assign at_last = (idx_q == head_job.last_idx);
	assign pop     = load && at_last;

	assign byte_out.valid         = valid_q;
	assign byte_out.out_byte      = byte_q;
	assign byte_out.last_of_run   = last_q;
	assign byte_out.bad_surrogate = bad_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_job.bytes[idx_q];
			bad_q  <= head_job.bad[idx_q];
			last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (byte_out.ready) begin
				valid_q <= 1'b0;
			end
			// advance within the job, restart on the next one
			if (load) begin
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder_unit.sv =====
`timescale 1ns / 1ps
// Path: the first byte of a unit is registered in the job queue and then in
// the output stage before byte_out.valid rises.
// Throughput: one code unit per cycle while each gives one byte and byte_out
// is ready; a unit that gives n results is sent by the back end as n bytes.
// Reset: arst_n clears the held surrogate, the job queue and the output stage.
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Front end classifies code units into byte jobs, back end streams the bytes.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	utt_unit_if.sink   unit_in,
	utt_byte_if.source byte_out
);
	import utt_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	job_t q_push_job;
	job_t q_head_job;

	utt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.unit_in(unit_in),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (q_push_job)
	);

	utt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_push_job),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_job  (q_head_job)
	);

	utt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_valid),
		.head_job  (q_head_job),
		.pop       (q_pop),
		.byte_out  (byte_out)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("job popped from an empty queue");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_out.valid && byte_out.bad_surrogate) |-> (byte_out.out_byte == ErrByte))
		else $error("error result carries a nonzero byte");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (byte_out.valid && byte_out.last_of_run))
		else $error("finished job not marked as end of run");
`endif

endmodule
